// ===== rtl/core/hss_pkg.sv =====
// Package for the hopping sine sample generator: widths, reset values,
// register indexes, transfer structs and the quarter-wave sine table.
// No dependencies.
`timescale 1ns / 1ps

package hss_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int MAX_SENSORS     = 8;
    localparam int MAX_CHANNELS    = 8;

    localparam int QUARTER_PTS = 1 << (SINE_TABLE_BITS - 2);
    localparam int POS_W       = SINE_TABLE_BITS - 2;
    localparam int ROM_IDX_W   = SINE_TABLE_BITS - 1;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 15;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LOWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_UPPER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = 3'd6;

    // Reset values
    localparam logic [31:0]        RST_STEP_LOWER    = 32'd2249297;
    localparam logic [31:0]        RST_STEP_UPPER    = 32'd17994379;
    localparam logic [GAIN_W-1:0]  RST_GAIN          = 15'd328;
    localparam logic [31:0]        RST_DWELL_SAMPLES = 32'd5000000;
    localparam logic [COUNT_W-1:0] RST_SENSOR_COUNT  = 4'd1;
    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 4'd1;

    typedef struct packed {
        logic                       upper;
        logic [SINE_TABLE_BITS-1:0] addr;
    } t_tone;

    typedef struct packed {
        logic                upper;
        logic [SAMPLE_W-1:0] word;
    } t_pcm;

    typedef logic [SAMPLE_W-1:0] t_rom [0:QUARTER_PTS];

    localparam longint TAYLOR_DIV [1:8] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                            64'sd110, 64'sd156, 64'sd210, 64'sd272};

    // Q30 Taylor series of the first quarter wave, rounded to Q1.15.
    function automatic t_rom build_rom();
        t_rom   rom;
        longint a;
        longint a2;
        longint term;
        longint sum;
        longint v;
        int     k;
        int     n;
        for (k = 0; k <= QUARTER_PTS; k++) begin
            a    = (longint'(k) * HALF_PI_Q30) >>> (SINE_TABLE_BITS - 2);
            a2   = (a * a) >>> 30;
            term = a;
            sum  = a;
            for (n = 1; n <= 8; n++) begin
                term = ((term * a2) >>> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 16384) >>> 15;
            if (v > 32767) begin
                v = 32767;
            end
            rom[k] = SAMPLE_W'(v);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ===== rtl/core/hss_phase.sv =====
// Phase accumulators, dwell counter and tone select; registers the table
// address of each tick. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_phase
    import hss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_step_lower,
    input  logic [31:0] i_step_upper,
    input  logic [31:0] i_dwell_samples,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output t_tone       o_tone
);

    logic [PHASE_BITS-1:0] r_phase_lo, n_phase_lo;
    logic [PHASE_BITS-1:0] r_phase_hi, n_phase_hi;
    logic [31:0]           r_dwell, n_dwell;
    logic                  r_upper, n_upper;
    logic                  r_valid;
    t_tone                 r_tone, n_tone;

    logic [PHASE_BITS-1:0] base_lo, base_hi, sel_phase;
    logic [31:0]           base_dwell, dwell_inc, limit;
    logic                  take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        base_lo    = i_restart ? '0 : r_phase_lo;
        base_hi    = i_restart ? '0 : r_phase_hi;
        base_dwell = i_restart ? '0 : r_dwell;
        sel_phase  = r_upper ? base_hi : base_lo;

        n_tone.upper = r_upper;
        n_tone.addr  = sel_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];

        n_phase_lo = base_lo + PHASE_BITS'(i_step_lower);
        n_phase_hi = base_hi + PHASE_BITS'(i_step_upper);

        // Zero dwell behaves as one
        limit     = (i_dwell_samples == '0) ? 32'd1 : i_dwell_samples;
        dwell_inc = base_dwell + 32'd1;
        if (dwell_inc >= limit) begin
            n_dwell = '0;
            n_upper = !r_upper;
        end else begin
            n_dwell = dwell_inc;
            n_upper = r_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_lo <= '0;
            r_phase_hi <= '0;
            r_dwell    <= '0;
            r_upper    <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_phase_lo <= n_phase_lo;
                r_phase_hi <= n_phase_hi;
                r_dwell    <= n_dwell;
                r_upper    <= n_upper;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tone <= n_tone;
        end
    end

    assign o_valid = r_valid;
    assign o_tone  = r_tone;

endmodule

// ===== rtl/core/hss_shaper.sv =====
// Two-stage sample shaper: quarter-wave table lookup, then gain multiply.
// Depends on hss_pkg (table, structs).
`timescale 1ns / 1ps

module hss_shaper
    import hss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_tone             i_tone,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_upper,
    output logic              o_negative,
    output logic [SAMPLE_W-1:0] o_prod
);

    logic                r_vb, r_vc;
    logic                r_upper_b, r_upper_c;
    logic [1:0]          r_quad_b;
    logic                r_neg_c;
    logic [SAMPLE_W-1:0] r_mag_b;
    logic [SAMPLE_W-1:0] r_prod_c;

    logic                 ready_b, ready_c;
    logic [1:0]           quad;
    logic [POS_W-1:0]     pos;
    logic [ROM_IDX_W-1:0] rom_idx;
    logic [SAMPLE_W-1:0]  n_mag;
    logic [30:0]          prod_full;

    assign ready_c = !r_vc || i_ready;
    assign ready_b = !r_vb || ready_c;
    assign o_ready = ready_b;

    always_comb begin
        quad = i_tone.addr[SINE_TABLE_BITS-1 -: 2];
        pos  = i_tone.addr[POS_W-1:0];
        // Mirror the index in odd quadrants
        rom_idx = quad[0] ? (ROM_IDX_W'(QUARTER_PTS) - {1'b0, pos}) : {1'b0, pos};
        n_mag   = SINE_ROM[rom_idx];
        prod_full = 31'(i_gain) * 31'(r_mag_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ready_b) begin
                r_vb <= i_valid;
            end
            if (ready_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_mag_b   <= n_mag;
            r_quad_b  <= quad;
            r_upper_b <= i_tone.upper;
        end
        if (ready_c && r_vb) begin
            r_prod_c  <= prod_full[30:15];
            r_neg_c   <= r_quad_b[1];
            r_upper_c <= r_upper_b;
        end
    end

    assign o_valid    = r_vc;
    assign o_upper    = r_upper_c;
    assign o_negative = r_neg_c;
    assign o_prod     = r_prod_c;

endmodule

// ===== rtl/core/hss_fanout.sv =====
// Output stage: saturates and signs the sample, optionally swaps bytes,
// and repeats it over sensors and channels. Depends on hss_pkg.
`timescale 1ns / 1ps

module hss_fanout
    import hss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [COUNT_W-1:0]  i_sensor_count,
    input  logic [COUNT_W-1:0]  i_channel_count,
    input  logic                i_swap_bytes,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_upper,
    input  logic                i_negative,
    input  logic [SAMPLE_W-1:0] i_prod,
    output logic                o_valid,
    input  logic                i_ready,
    output t_pcm                o_pcm,
    output logic [INDEX_W-1:0]  o_sensor,
    output logic [INDEX_W-1:0]  o_channel,
    output logic                o_last
);

    logic                r_valid;
    t_pcm                r_pcm, n_pcm;
    logic [INDEX_W-1:0]  r_s, r_c;

    logic [COUNT_W-1:0]  ns, nc;
    logic                s_end, c_end, last, take, load;
    logic [SAMPLE_W-1:0] sat, word;

    always_comb begin
        ns = (i_sensor_count > COUNT_W'(MAX_SENSORS)) ? COUNT_W'(MAX_SENSORS) : i_sensor_count;
        nc = (i_channel_count > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS)
                                                        : i_channel_count;
        s_end = (({1'b0, r_s} + COUNT_W'(1)) == ns);
        c_end = (({1'b0, r_c} + COUNT_W'(1)) == nc);
        last  = s_end && c_end;

        if (i_negative) begin
            sat  = (i_prod > 16'h8000) ? 16'h8000 : i_prod;
            word = 16'(17'h10000 - {1'b0, sat});
        end else begin
            sat  = (i_prod > 16'h7fff) ? 16'h7fff : i_prod;
            word = sat;
        end
        n_pcm.upper = i_upper;
        n_pcm.word  = i_swap_bytes ? {word[7:0], word[15:8]} : word;
    end

    assign o_ready = !r_valid || (i_ready && last);
    assign take    = i_valid && o_ready;
    // Drop the tick when either count is zero
    assign load    = take && (ns != '0) && (nc != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_s     <= '0;
            r_c     <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_s     <= '0;
                r_c     <= '0;
            end else if (r_valid && i_ready) begin
                if (last) begin
                    r_valid <= 1'b0;
                end else if (c_end) begin
                    r_c <= '0;
                    r_s <= r_s + INDEX_W'(1);
                end else begin
                    r_c <= r_c + INDEX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pcm <= n_pcm;
        end
    end

    assign o_valid   = r_valid;
    assign o_pcm     = r_pcm;
    assign o_sensor  = r_s;
    assign o_channel = r_c;
    assign o_last    = last;

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (({1'b0, r_s} < ns) && ({1'b0, r_c} < nc)))
        else $error("copy index beyond configured count");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !last) |=> (r_valid && $stable(r_pcm)))
        else $error("sample changed within one tick's copies");

    a_no_early_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !(i_ready && last)) |-> !load)
        else $error("new tick loaded before last copy transferred");

endmodule

// ===== rtl/core/hopping_sine_sample_generator.sv =====
// Hopping sine sample generator: phase, table lookup, multiply and fanout stages.
// Each tick is registered by the phase, lookup, multiply and fanout stages in order.
// Throughput: one tick per cycle at one copy unless the output stalls; else the
// fanout holds each tick for its sensors x channels copies; zero-count ticks drop.
// Synchronous active-low reset clears phases, dwell count and valids, loads
// register defaults and selects the upper tone.
`timescale 1ns / 1ps

module hopping_sine_sample_generator
    import hss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_sample_word,
    output logic [INDEX_W-1:0]    o_sensor_index,
    output logic [INDEX_W-1:0]    o_channel_index,
    output logic                  o_upper_active,
    output logic                  o_last_copy
);

    logic [31:0]        r_step_lower, r_step_upper, r_dwell_samples;
    logic [GAIN_W-1:0]  r_gain;
    logic [COUNT_W-1:0] r_sensor_count, r_channel_count;
    logic               r_swap_bytes;

    logic                tone_valid, tone_ready;
    t_tone               tone;
    logic                shp_valid, shp_ready, shp_upper, shp_neg;
    logic [SAMPLE_W-1:0] shp_prod;
    t_pcm                pcm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_lower    <= RST_STEP_LOWER;
            r_step_upper    <= RST_STEP_UPPER;
            r_gain          <= RST_GAIN;
            r_dwell_samples <= RST_DWELL_SAMPLES;
            r_sensor_count  <= RST_SENSOR_COUNT;
            r_channel_count <= RST_CHANNEL_COUNT;
            r_swap_bytes    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_LOWER:    r_step_lower    <= i_cfg_data;
                REG_STEP_UPPER:    r_step_upper    <= i_cfg_data;
                REG_GAIN:          r_gain          <= i_cfg_data[GAIN_W-1:0];
                REG_DWELL_SAMPLES: r_dwell_samples <= i_cfg_data;
                REG_SENSOR_COUNT:  r_sensor_count  <= i_cfg_data[COUNT_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[COUNT_W-1:0];
                REG_SWAP_BYTES:    r_swap_bytes    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hss_phase u_phase (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_lower    (r_step_lower),
        .i_step_upper    (r_step_upper),
        .i_dwell_samples (r_dwell_samples),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_restart       (i_restart),
        .o_valid         (tone_valid),
        .i_ready         (tone_ready),
        .o_tone          (tone)
    );

    hss_shaper u_shaper (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gain     (r_gain),
        .i_valid    (tone_valid),
        .o_ready    (tone_ready),
        .i_tone     (tone),
        .o_valid    (shp_valid),
        .i_ready    (shp_ready),
        .o_upper    (shp_upper),
        .o_negative (shp_neg),
        .o_prod     (shp_prod)
    );

    hss_fanout u_fanout (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sensor_count  (r_sensor_count),
        .i_channel_count (r_channel_count),
        .i_swap_bytes    (r_swap_bytes),
        .i_valid         (shp_valid),
        .o_ready         (shp_ready),
        .i_upper         (shp_upper),
        .i_negative      (shp_neg),
        .i_prod          (shp_prod),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_pcm           (pcm),
        .o_sensor        (o_sensor_index),
        .o_channel       (o_channel_index),
        .o_last          (o_last_copy)
    );

    assign o_sample_word  = pcm.word;
    assign o_upper_active = pcm.upper;

endmodule
